### design/masked_byte_pattern_scan_defines.svh
// Assertion macros for the masked byte pattern scan.
`ifndef MASKED_BYTE_PATTERN_SCAN_DEFINES_SVH
`define MASKED_BYTE_PATTERN_SCAN_DEFINES_SVH

// Same-cycle implication, held off while in reset.
`define MBPS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off while in reset.
`define MBPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/mbps_pkg.sv
package mbps_pkg;

    // Default sizing
    localparam int MAX_PATTERN_DEF = 16;
    localparam int OFFSET_BITS_DEF = 32;

    // Configuration port sizing
    localparam int PADDR_W    = 6;
    localparam int PDATA_W    = 64;
    localparam int REG_IDX_LO = 3;
    localparam int REG_IDX_W  = 3;

    // Register reset values
    localparam logic [4:0] LENGTH_RESET = 5'd1;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_PATTERN_LOW  = 3'd0,
        REG_PATTERN_HIGH = 3'd1,
        REG_WILDCARD     = 3'd2,
        REG_LENGTH       = 3'd3,
        REG_BASE_ADDRESS = 3'd4
    } reg_index_t;

    typedef struct packed {
        logic [63:0] pattern_bytes_low;
        logic [63:0] pattern_bytes_high;
        logic [15:0] wildcard_mask;
        logic [4:0]  pattern_length;
        logic [63:0] base_address;
    } cfg_t;

    typedef struct packed {
        logic        emit;
        logic        found;
        logic [63:0] address;
    } result_t;

endpackage

### design/mbps_cfg.sv
module mbps_cfg
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mbps_pkg::PADDR_W-1:0] paddr,
    input  logic [mbps_pkg::PDATA_W-1:0] pwdata,
    output logic [mbps_pkg::PDATA_W-1:0] prdata,
    output logic                         pready,
    output mbps_pkg::cfg_t               cfg
);

    mbps_pkg::cfg_t         cfg_reg;
    mbps_pkg::cfg_t         cfg_next;
    mbps_pkg::reg_index_t   reg_index;
    logic                   write_en;

    assign pready    = 1'b1;
    assign write_en  = psel && penable && pwrite;
    assign reg_index = mbps_pkg::reg_index_t'(
        paddr[mbps_pkg::REG_IDX_LO +: mbps_pkg::REG_IDX_W]);
    assign cfg       = cfg_reg;

    // Decode the write request; drop unknown indexes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (write_en)
        begin
            unique case (reg_index)
                mbps_pkg::REG_PATTERN_LOW:  cfg_next.pattern_bytes_low  = pwdata;
                mbps_pkg::REG_PATTERN_HIGH: cfg_next.pattern_bytes_high = pwdata;
                mbps_pkg::REG_WILDCARD:     cfg_next.wildcard_mask      = pwdata[15:0];
                mbps_pkg::REG_LENGTH:       cfg_next.pattern_length     = pwdata[4:0];
                mbps_pkg::REG_BASE_ADDRESS: cfg_next.base_address       = pwdata;
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    // Read back the addressed register
    always_comb
    begin
        unique case (reg_index)
            mbps_pkg::REG_PATTERN_LOW:  prdata = cfg_reg.pattern_bytes_low;
            mbps_pkg::REG_PATTERN_HIGH: prdata = cfg_reg.pattern_bytes_high;
            mbps_pkg::REG_WILDCARD:     prdata = {48'd0, cfg_reg.wildcard_mask};
            mbps_pkg::REG_LENGTH:       prdata = {59'd0, cfg_reg.pattern_length};
            mbps_pkg::REG_BASE_ADDRESS: prdata = cfg_reg.base_address;
            default:                    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pattern_bytes_low  <= '0;
            cfg_reg.pattern_bytes_high <= '0;
            cfg_reg.wildcard_mask      <= '0;
            cfg_reg.pattern_length     <= mbps_pkg::LENGTH_RESET;
            cfg_reg.base_address       <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### design/mbps_scan.sv
module mbps_scan
#(
    parameter int MAX_PATTERN = mbps_pkg::MAX_PATTERN_DEF,
    parameter int OFFSET_BITS = mbps_pkg::OFFSET_BITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic [7:0]        image_byte,
    input  logic              last_byte,
    input  mbps_pkg::cfg_t    cfg,
    output mbps_pkg::result_t result
);

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int PAT_W = 8 * MAX_PATTERN;

    // Older bytes of the window; the newest byte is the request itself
    logic [7:0]             window_reg [MAX_PATTERN-1];
    logic [7:0]             full_win   [MAX_PATTERN];

    // Pattern realigned to window slots from the live registers
    logic [PAT_W-1:0]       aligned;
    logic [MAX_PATTERN-1:0] care_mask;
    logic [LEN_W-1:0]       len_used;

    logic [OFFSET_BITS-1:0] count_reg;
    logic [OFFSET_BITS-1:0] count_next;
    logic                   done_reg;
    logic                   done_next;

    logic [127:0]           pat_all;
    logic [PAT_W-1:0]       pat_rev;
    logic [MAX_PATTERN-1:0] wild_rev;
    logic [MAX_PATTERN-1:0] wild_al;
    logic [LEN_W-1:0]       shift_amt;
    logic [MAX_PATTERN-1:0] slot_ok;
    logic [OFFSET_BITS-1:0] count_inc;
    logic [OFFSET_BITS-1:0] len_ext;
    logic [OFFSET_BITS-1:0] offset;
    logic                   enough;
    logic                   hit;

    // Clamp the length and realign pattern and wildcards to window slots:
    // slot k pairs with pattern byte len-1-k
    always_comb
    begin
        if (cfg.pattern_length == 5'd0)
            len_used = LEN_W'(1);
        else if (cfg.pattern_length > 5'(MAX_PATTERN))
            len_used = LEN_W'(MAX_PATTERN);
        else
            len_used = LEN_W'(cfg.pattern_length);

        pat_all = {cfg.pattern_bytes_high, cfg.pattern_bytes_low};
        for (int j = 0; j < MAX_PATTERN; j++)
        begin
            pat_rev[8*j +: 8] = pat_all[8*(MAX_PATTERN-1-j) +: 8];
            wild_rev[j]       = cfg.wildcard_mask[MAX_PATTERN-1-j];
        end

        shift_amt = LEN_W'(MAX_PATTERN) - len_used;
        aligned   = pat_rev >> {shift_amt, 3'b000};
        wild_al   = wild_rev >> shift_amt;
        for (int k = 0; k < MAX_PATTERN; k++)
            care_mask[k] = (LEN_W'(k) < len_used) && !wild_al[k];
    end

    // Compare the full window against the aligned pattern
    always_comb
    begin
        full_win[0] = image_byte;
        for (int k = 1; k < MAX_PATTERN; k++)
            full_win[k] = window_reg[k-1];
        for (int k = 0; k < MAX_PATTERN; k++)
            slot_ok[k] = !care_mask[k] || (full_win[k] == aligned[8*k +: 8]);
    end

    // Count the byte, saturating, and form the match offset
    always_comb
    begin
        count_inc = (&count_reg) ? count_reg : count_reg + OFFSET_BITS'(1);
        len_ext   = OFFSET_BITS'(len_used);
        enough    = count_inc >= len_ext;
        offset    = count_inc - len_ext;
        hit       = !done_reg && enough && (&slot_ok);

        result.emit    = hit || (last_byte && !done_reg);
        result.found   = hit;
        result.address = hit ? cfg.base_address + 64'(offset) : 64'd0;

        // Clear the scan after its last byte
        if (last_byte)
        begin
            count_next = '0;
            done_next  = 1'b0;
        end
        else
        begin
            count_next = count_inc;
            done_next  = done_reg || hit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else if (advance)
        begin
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // Shift the window on each completed request
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            window_reg[0] <= image_byte;
            for (int k = 1; k < MAX_PATTERN - 1; k++)
                window_reg[k] <= window_reg[k-1];
        end
    end

endmodule

### design/masked_byte_pattern_scan.sv
// An accepted request waits in the input register until the result register is free.
// Throughput: one image byte per cycle unless a stalled result holds it; the
// window compare and address add share a single stage between the two registers.
// A byte that ends a scan without a new match and without a miss gives no result.
// Reset clears the scan count, match flag and valid bits, and sets the
// registers to pattern length 1 with all other fields zero.
`include "masked_byte_pattern_scan_defines.svh"

module masked_byte_pattern_scan
#(
    parameter int MAX_PATTERN = mbps_pkg::MAX_PATTERN_DEF,
    parameter int OFFSET_BITS = mbps_pkg::OFFSET_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mbps_pkg::PADDR_W-1:0] paddr,
    input  logic [mbps_pkg::PDATA_W-1:0] pwdata,
    output logic [mbps_pkg::PDATA_W-1:0] prdata,
    output logic                         pready,

    input  logic                         image_valid,
    output logic                         image_stall,
    input  logic [7:0]                   image_byte,
    input  logic                         last_byte,

    output logic                         result_valid,
    input  logic                         result_stall,
    output logic                         found,
    output logic [63:0]                  match_address
);

    mbps_pkg::cfg_t    cfg;
    mbps_pkg::result_t scan_res;

    logic        in_valid_reg;
    logic        in_valid_next;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic        found_reg;
    logic [63:0] address_reg;

    logic        accept;
    logic        out_free;
    logic        advance;

    mbps_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mbps_scan
    #(
        .MAX_PATTERN (MAX_PATTERN),
        .OFFSET_BITS (OFFSET_BITS)
    )
    u_scan
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .image_byte (in_byte_reg),
        .last_byte  (in_last_reg),
        .cfg        (cfg),
        .result     (scan_res)
    );

    // Handshake: the input stage moves on whenever the result slot frees up
    assign out_free    = !out_valid_reg || !result_stall;
    assign advance     = in_valid_reg && out_free;
    assign image_stall = in_valid_reg && !out_free;
    assign accept      = image_valid && !image_stall;

    assign result_valid  = out_valid_reg;
    assign found         = found_reg;
    assign match_address = address_reg;

    always_comb
    begin
        if (accept)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;

        if (out_free)
            out_valid_next = advance && scan_res.emit;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the input request
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_byte_reg <= image_byte;
            in_last_reg <= last_byte;
        end
    end

    // Load the result register
    always_ff @(posedge clk)
    begin
        if (advance && scan_res.emit)
        begin
            found_reg   <= scan_res.found;
            address_reg <= scan_res.address;
        end
    end

    `MBPS_ASSERT_NEXT(a_result_loaded, clk, rst_n, advance && scan_res.emit,
        out_valid_reg && (found_reg == $past(scan_res.found)),
        "emitted result not loaded into result register")

    `MBPS_ASSERT_NEXT(a_input_held, clk, rst_n, in_valid_reg && !advance,
        in_valid_reg && $stable(in_byte_reg) && $stable(in_last_reg),
        "pending input request lost while result slot busy")

    `MBPS_ASSERT_NOW(a_miss_zero_address, clk, rst_n, out_valid_reg && !found_reg,
        address_reg == 64'd0,
        "not-found result carries a nonzero address")

endmodule

### tb/sv/tb_masked_byte_pattern_scan.sv
module tb_masked_byte_pattern_scan;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 4;
    localparam int PHASE_BYTES    = 200;
    localparam int RANDOM_PHASES  = 8;

    typedef struct packed {
        logic [7:0] data;
        logic       is_last;
    } scan_req_t;

    typedef struct packed {
        logic        found;
        logic [63:0] address;
    } hit_t;

    typedef enum int {
        SCAN_PLANTED,
        SCAN_BROKEN,
        SCAN_NOISE
    } scan_kind_t;

    logic                           clk;
    logic                           rst_n = 1'b0;
    logic                           psel = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite = 1'b0;
    logic [mbps_pkg::PADDR_W-1:0]   paddr = '0;
    logic [mbps_pkg::PDATA_W-1:0]   pwdata = '0;
    logic [mbps_pkg::PDATA_W-1:0]   prdata;
    logic                           pready;
    logic                           image_valid = 1'b0;
    logic                           image_stall;
    logic [7:0]                     image_byte = '0;
    logic                           last_byte = 1'b0;
    logic                           result_valid;
    logic                           result_stall = 1'b0;
    logic                           found;
    logic [63:0]                    match_address;

    // Register copies kept by the predictor
    logic [63:0] cfg_lo = '0;
    logic [63:0] cfg_hi = '0;
    logic [15:0] cfg_mask = '0;
    logic [4:0]  cfg_len = mbps_pkg::LENGTH_RESET;
    logic [63:0] cfg_base = '0;

    // Scan state kept by the predictor
    logic [7:0]  win [0:15];
    logic [31:0] seen = '0;
    bit          matched = 1'b0;

    scan_req_t scan_q [$];
    hit_t      hits_q [$];
    scan_req_t cur_req = '0;
    bit        req_pending = 1'b0;
    int        send_gap = 0;
    bit        send_idle = 1'b0;
    int        stall_left = 0;
    bit        recv_idle = 1'b0;
    int        fail_cnt = 0;
    int        quiet_cycles = 0;

    masked_byte_pattern_scan u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .image_valid   (image_valid),
        .image_stall   (image_stall),
        .image_byte    (image_byte),
        .last_byte     (last_byte),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .found         (found),
        .match_address (match_address)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Length in use: zero acts as one, anything past 16 acts as 16
    function automatic int used_len();
        if (cfg_len == 5'd0)
            return 1;
        if (cfg_len > 5'd16)
            return 16;
        return int'(cfg_len);
    endfunction

    function automatic logic [7:0] pat_byte(input int pos);
        logic [127:0] pat;
        pat = {cfg_hi, cfg_lo};
        return pat[8*pos +: 8];
    endfunction

    function automatic void clear_scan_state();
        for (int k = 0; k < 16; k++)
            win[k] = 8'h00;
        seen = '0;
        matched = 1'b0;
    endfunction

    // Shift in one byte, compare the window and queue any result it causes
    function automatic void predict_scan_byte(input logic [7:0] data, input logic is_last);
        int   len;
        bit   hit;
        hit_t res;
        len = used_len();
        for (int k = 15; k > 0; k--)
            win[k] = win[k-1];
        win[0] = data;
        if (seen != '1)
            seen++;
        hit = !matched && (64'(seen) >= 64'(len));
        for (int i = 0; i < len; i++)
            if (!cfg_mask[i] && win[len-1-i] != pat_byte(i))
                hit = 1'b0;
        if (hit)
        begin
            matched = 1'b1;
            res.found = 1'b1;
            res.address = cfg_base + (64'(seen) - 64'(len));
            hits_q.push_back(res);
        end
        if (is_last)
        begin
            if (!matched)
            begin
                res.found = 1'b0;
                res.address = '0;
                hits_q.push_back(res);
            end
            clear_scan_state();
        end
    endfunction

    // Request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_valid <= 1'b0;
            image_byte <= '0;
            last_byte <= 1'b0;
            req_pending = 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (image_valid && !image_stall)
            begin
                predict_scan_byte(cur_req.data, cur_req.is_last);
                req_pending = 1'b0;
                if ($urandom_range(0, 31) == 0)
                    send_idle = !send_idle;
                send_gap = send_idle ? $urandom_range(0, 4) : 0;
            end
            if (!req_pending)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (scan_q.size() > 0)
                begin
                    cur_req = scan_q.pop_front();
                    req_pending = 1'b1;
                end
            end
            image_valid <= req_pending;
            image_byte <= cur_req.data;
            last_byte <= cur_req.is_last;
        end
    end

    // Result monitor and receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        hit_t exp_hit;
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (hits_q.size() == 0)
                begin
                    $error("unexpected result: found=%0b match_address=%h", found, match_address);
                    fail_cnt++;
                end
                else
                begin
                    exp_hit = hits_q.pop_front();
                    if (found !== exp_hit.found)
                    begin
                        $error("found: expected %0b, actual %0b", exp_hit.found, found);
                        fail_cnt++;
                    end
                    if (match_address !== exp_hit.address)
                    begin
                        $error("match_address: expected %h, actual %h",
                               exp_hit.address, match_address);
                        fail_cnt++;
                    end
                end
                if ($urandom_range(0, 15) == 0)
                    recv_idle = !recv_idle;
                stall_left = recv_idle ? $urandom_range(0, 4) : 0;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                result_stall <= 1'b1;
            end
            else
                result_stall <= 1'b0;
        end
    end

    // Watchdog: drop the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((image_valid && !image_stall) || (result_valid && !result_stall)
            || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Setup cycle, then access cycle; the register takes the value at the access edge
    task automatic write_reg(input mbps_pkg::reg_index_t idx, input logic [63:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, {mbps_pkg::REG_IDX_LO{1'b0}}};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            mbps_pkg::REG_PATTERN_LOW:  cfg_lo = value;
            mbps_pkg::REG_PATTERN_HIGH: cfg_hi = value;
            mbps_pkg::REG_WILDCARD:     cfg_mask = value[15:0];
            mbps_pkg::REG_LENGTH:       cfg_len = value[4:0];
            mbps_pkg::REG_BASE_ADDRESS: cfg_base = value;
            default: ;
        endcase
    endtask

    task automatic set_scan_config(input logic [63:0] lo, input logic [63:0] hi,
                                   input logic [63:0] mask, input logic [63:0] len,
                                   input logic [63:0] base);
        write_reg(mbps_pkg::REG_PATTERN_LOW, lo);
        write_reg(mbps_pkg::REG_PATTERN_HIGH, hi);
        write_reg(mbps_pkg::REG_WILDCARD, mask);
        write_reg(mbps_pkg::REG_LENGTH, len);
        write_reg(mbps_pkg::REG_BASE_ADDRESS, base);
    endtask

    // Hold until every request is taken and every result is back, then let the pipe settle
    task automatic drain_results();
        while (req_pending || scan_q.size() != 0 || hits_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic void push_byte(input logic [7:0] data, input logic is_last);
        scan_req_t req;
        req.data = data;
        req.is_last = is_last;
        scan_q.push_back(req);
    endfunction

    // Half the bytes taken from the pattern so that stray matches happen too
    function automatic logic [7:0] noise_byte();
        if ($urandom_range(0, 1) == 0)
            return pat_byte($urandom_range(0, 15));
        return 8'($urandom);
    endfunction

    // Queue one scan; returns the number of bytes it holds
    function automatic int queue_scan();
        scan_kind_t  kind;
        int          n;
        int          len;
        int          pos;
        int          brk;
        int          r;
        logic [7:0]  bytes [$];
        len = used_len();
        r = $urandom_range(0, 9);
        kind = (r < 6) ? SCAN_PLANTED : (r < 8) ? SCAN_BROKEN : SCAN_NOISE;
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(40, 90) : $urandom_range(1, 24);
        if (kind != SCAN_NOISE && n < len)
            n = len + $urandom_range(0, 4);
        for (int i = 0; i < n; i++)
            bytes.push_back(noise_byte());
        if (kind != SCAN_NOISE)
        begin
            pos = $urandom_range(0, n - len);
            for (int i = 0; i < len; i++)
                bytes[pos+i] = cfg_mask[i] ? 8'($urandom) : pat_byte(i);
            if (kind == SCAN_BROKEN)
            begin
                brk = $urandom_range(0, len - 1);
                if (!cfg_mask[brk])
                    bytes[pos+brk] = bytes[pos+brk] ^ 8'($urandom_range(1, 255));
            end
        end
        for (int i = 0; i < n; i++)
            push_byte(bytes[i], i == n - 1);
        return n;
    endfunction

    // Stimulus
    initial
    begin
        int          phase_bytes;
        bit          paused;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mask;
        logic [63:0] len;
        logic [63:0] base;
        int          r;

        clear_scan_state();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: one zero byte matches at once, then a miss on a lone byte
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b1);
        push_byte(8'hFF, 1'b1);
        drain_results();

        // Zero pattern against a zero window: a short scan must miss,
        // then a match on the last byte whose address wraps past the top
        set_scan_config(64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 64'd4,
                        64'hFFFF_FFFF_FFFF_FFFF);
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b1);
        push_byte(8'hAA, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b1);
        drain_results();

        // Length zero acts as one; mask bits past the length are ignored;
        // bytes after a match give nothing
        set_scan_config(64'h0000_0000_0000_00FF, 64'h0, 64'hFFFF_FFFF_FFFF_FFFE, 64'd0,
                        64'h8000_0000_0000_0000);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b1);
        drain_results();

        // Random phases, each with its own settings
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            r = $urandom_range(0, 7);
            lo = {$urandom, $urandom};
            hi = {$urandom, $urandom};
            if (r == 0)
                lo = 64'h0;
            else if (r == 1)
                hi = 64'hFFFF_FFFF_FFFF_FFFF;
            r = $urandom_range(0, 5);
            mask = {$urandom, 16'($urandom), 16'h0};
            if (r == 0)
                mask[15:0] = 16'h0000;
            else if (r == 1)
                mask[15:0] = 16'hFFFF;
            else
                mask[15:0] = 16'($urandom & $urandom);
            if (ph == 0)
                len = 64'd16;
            else if (ph == 1)
                len = 64'd31;
            else
            begin
                r = $urandom_range(0, 9);
                case (r)
                    0: len = 64'd0;
                    1: len = 64'd1;
                    2: len = 64'd16;
                    3: len = 64'($urandom_range(17, 31));
                    default: len = 64'($urandom_range(2, 15));
                endcase
                len[63:5] = 59'($urandom);
            end
            r = $urandom_range(0, 3);
            if (r == 0)
                base = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 40));
            else if (r == 1)
                base = 64'h0;
            else
                base = {$urandom, $urandom};
            set_scan_config(lo, hi, mask, len, base);

            phase_bytes = 0;
            paused = 1'b0;
            while (phase_bytes < PHASE_BYTES)
            begin
                // Hold the sender once until every result is in
                if (ph == 3 && !paused && phase_bytes >= PHASE_BYTES / 2)
                begin
                    drain_results();
                    paused = 1'b1;
                end
                phase_bytes += queue_scan();
            end
            drain_results();
        end

        if (fail_cnt == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
